[rtl/ocv_pkg.sv]
package ocv_pkg;

    // Image layout
    localparam int IMAGE_BYTES = 6781;
    localparam int OFF_W = 13;
    localparam logic [OFF_W-1:0] LAST_OFFSET = OFF_W'(IMAGE_BYTES - 1);
    localparam int SECTIONS = 9;

    localparam logic [OFF_W-1:0] SEC_FIRST [SECTIONS] = '{
        13'h0000, 13'h0020, 13'h0045, 13'h0066, 13'h0CAB,
        13'h0CE1, 13'h143F, 13'h1641, 13'h19DF};
    localparam logic [OFF_W-1:0] SEC_CHECK [SECTIONS] = '{
        13'h001F, 13'h0044, 13'h0065, 13'h008B, 13'h0CE0,
        13'h143E, 13'h1640, 13'h19DE, 13'h1A7C};

    localparam logic [7:0] SEC_FLAG = 8'h01;
    localparam logic [7:0] SUM_MOD = 8'hFF;

    // ID and version byte offsets
    localparam logic [OFF_W-1:0] OFF_MODULE_ID   = 13'd1;
    localparam logic [OFF_W-1:0] OFF_PLATFORM_ID = 13'd2;
    localparam logic [OFF_W-1:0] OFF_LENS_ID     = 13'd8;
    localparam logic [OFF_W-1:0] OFF_VCM_ID      = 13'd9;
    localparam logic [OFF_W-1:0] OFF_DRIVER_ID   = 13'd10;
    localparam logic [OFF_W-1:0] OFF_VER_FIRST   = 13'd11;
    localparam logic [OFF_W-1:0] OFF_VER_LAST    = 13'd14;

    // AWB words: R, B, G unit, then R, B, G golden, high byte first
    localparam logic [OFF_W-1:0] OFF_AWB_FIRST = 13'h0CAC;
    localparam logic [OFF_W-1:0] OFF_AWB_LAST  = 13'h0CB7;
    localparam int AWB_WORDS = 6;

    // Metric arithmetic
    localparam int FRAC_SHIFT = 20;
    localparam int DIV_BITS = 32 + FRAC_SHIFT;
    localparam int METRIC_W = 54;
    localparam logic [METRIC_W-1:0] METRIC_ONES = '1;

    // Status codes
    localparam logic [2:0] ST_NORMAL    = 3'd0;
    localparam logic [2:0] ST_GROUP_BAD = 3'd1;
    localparam logic [2:0] ST_INFO_BAD  = 3'd2;
    localparam logic [2:0] ST_SUM_BAD   = 3'd3;
    localparam logic [2:0] ST_AWB_BAD   = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_MODULE_ID   = 3'd0;
    localparam logic [2:0] REG_LENS_ID     = 3'd1;
    localparam logic [2:0] REG_VCM_ID      = 3'd2;
    localparam logic [2:0] REG_DRIVER_ID   = 3'd3;
    localparam logic [2:0] REG_PLATFORM_ID = 3'd4;
    localparam logic [2:0] REG_CAL_VERSION = 3'd5;
    localparam logic [2:0] REG_AWB_LIMIT   = 3'd6;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  module_id;
        logic [7:0]  lens_id;
        logic [7:0]  vcm_id;
        logic [7:0]  driver_id;
        logic [7:0]  platform_id;
        logic [31:0] cal_version;
        logic [31:0] awb_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        module_id: 8'd5, lens_id: 8'd7, vcm_id: 8'd9, driver_id: 8'd3,
        platform_id: 8'd3, cal_version: 32'hFF000B01, awb_limit: 32'd10485};

    // One finished image, handed from front to back
    typedef struct packed {
        logic                          flag_fail;
        logic                          info_fail;
        logic                          sum_fail;
        logic [AWB_WORDS-1:0][15:0]    awb;
    } job_t;

endpackage

[rtl/ocv_front.sv]
module ocv_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    eeprom_byte,
    input  ocv_pkg::cfg_t cfg,
    output logic          job_push,
    output ocv_pkg::job_t job
);

    logic [ocv_pkg::OFF_W-1:0] off_reg, off_next;
    logic [7:0]  res_reg, res_next;
    logic [31:0] ver_reg, ver_next;
    logic        flag_reg, flag_next;
    logic        id_reg, id_next;
    logic        sum_reg, sum_next;
    logic [ocv_pkg::AWB_WORDS-1:0][15:0] awb_reg, awb_next;
    logic        last;
    logic [8:0]  res_add;
    logic [3:0]  awb_rel;
    logic        in_sec;

    // Classify the byte against the section table and the field offsets
    always_comb
    begin
        flag_next = flag_reg;
        id_next = id_reg;
        sum_next = sum_reg;
        res_next = res_reg;
        ver_next = ver_reg;
        awb_next = awb_reg;
        in_sec = 1'b0;
        res_add = {1'b0, res_reg} + {1'b0, eeprom_byte};
        awb_rel = 4'(off_reg - ocv_pkg::OFF_AWB_FIRST);
        for (int k = 0; k < ocv_pkg::SECTIONS; k++)
        begin
            if (off_reg == ocv_pkg::SEC_FIRST[k])
            begin
                if (eeprom_byte != ocv_pkg::SEC_FLAG)
                    flag_next = 1'b1;
                res_next = '0;
            end
            else if (off_reg == ocv_pkg::SEC_CHECK[k])
            begin
                if ({1'b0, eeprom_byte} != {1'b0, res_reg} + 9'd1)
                    sum_next = 1'b1;
            end
            else if (off_reg > ocv_pkg::SEC_FIRST[k] && off_reg < ocv_pkg::SEC_CHECK[k])
            begin
                in_sec = 1'b1;
            end
        end
        // Keep the payload sum reduced modulo 255
        if (in_sec)
            res_next = (res_add >= {1'b0, ocv_pkg::SUM_MOD})
                     ? 8'(res_add - {1'b0, ocv_pkg::SUM_MOD}) : res_add[7:0];
        case (off_reg)
            ocv_pkg::OFF_MODULE_ID:   if (eeprom_byte != cfg.module_id)   id_next = 1'b1;
            ocv_pkg::OFF_PLATFORM_ID: if (eeprom_byte != cfg.platform_id) id_next = 1'b1;
            ocv_pkg::OFF_LENS_ID:     if (eeprom_byte != cfg.lens_id)     id_next = 1'b1;
            ocv_pkg::OFF_VCM_ID:      if (eeprom_byte != cfg.vcm_id)      id_next = 1'b1;
            ocv_pkg::OFF_DRIVER_ID:   if (eeprom_byte != cfg.driver_id)   id_next = 1'b1;
            default: ;
        endcase
        if (off_reg >= ocv_pkg::OFF_VER_FIRST && off_reg <= ocv_pkg::OFF_VER_LAST)
            ver_next = {ver_reg[23:0], eeprom_byte};
        if (off_reg >= ocv_pkg::OFF_AWB_FIRST && off_reg <= ocv_pkg::OFF_AWB_LAST)
        begin
            if (awb_rel[0])
                awb_next[awb_rel[3:1]][7:0] = eeprom_byte;
            else
                awb_next[awb_rel[3:1]][15:8] = eeprom_byte;
        end
    end

    assign last = off_reg >= ocv_pkg::LAST_OFFSET;
    assign off_next = last ? '0 : off_reg + 1'b1;

    // Hand the finished image to the back end
    assign job_push = accept && last;
    assign job.flag_fail = flag_next;
    assign job.info_fail = id_next || (ver_next != cfg.cal_version);
    assign job.sum_fail = sum_next;
    assign job.awb = awb_next;

    // Advance per image state, clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            res_reg <= '0;
            ver_reg <= '0;
            flag_reg <= 1'b0;
            id_reg <= 1'b0;
            sum_reg <= 1'b0;
        end
        else if (accept)
        begin
            off_reg <= off_next;
            res_reg <= last ? '0 : res_next;
            ver_reg <= last ? '0 : ver_next;
            flag_reg <= last ? 1'b0 : flag_next;
            id_reg <= last ? 1'b0 : id_next;
            sum_reg <= last ? 1'b0 : sum_next;
        end
    end

    // Capture AWB words, kept across images
    always_ff @(posedge clk)
    begin
        if (accept)
            awb_reg <= awb_next;
    end

endmodule

[rtl/ocv_queue.sv]
module ocv_queue #(
    parameter int DEPTH = ocv_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ocv_pkg::job_t wr_data,
    input  logic          rd_en,
    output ocv_pkg::job_t rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    ocv_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign full = cnt_reg == CNT_FULL;
    assign empty = cnt_reg == '0;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Move pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue count beyond depth");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_rd |=> $stable(cnt_reg))
        else $error("queue count moved while full");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers differ while empty");

endmodule

[rtl/ocv_back.sv]
module ocv_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_empty,
    input  ocv_pkg::job_t                 job,
    output logic                          job_pop,
    input  logic [31:0]                   awb_limit,
    input  logic                          pop,
    output logic                          out_valid,
    output logic [2:0]                    status,
    output logic [ocv_pkg::METRIC_W-1:0]  awb_metric
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam int NB = ocv_pkg::DIV_BITS;
    localparam int CNTW = $clog2(NB);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(NB - 1);
    localparam int AW = ocv_pkg::METRIC_W + 1;

    logic [2:0]  state_reg, state_next;
    ocv_pkg::job_t job_reg, job_next;
    logic [1:0]  term_reg, term_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [NB-1:0] num_reg, num_next;
    logic [NB-1:0] quo_reg, quo_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic        zero_reg, zero_next;
    logic        ov_reg, ov_next;
    logic [2:0]  st_reg, st_next;
    logic [ocv_pkg::METRIC_W-1:0] met_reg, met_next;

    logic [15:0] unit, golden, diff;
    logic [32:0] rsh;
    logic        ge;
    logic [ocv_pkg::METRIC_W-1:0] metric;
    logic        awb_out;
    logic        any_zero;

    assign any_zero = (job.awb[3] == '0) || (job.awb[4] == '0) || (job.awb[5] == '0);

    // Pick the unit and golden word of the current term
    always_comb
    begin
        case (term_reg)
            2'd0:    begin unit = job_reg.awb[0]; golden = job_reg.awb[3]; end
            2'd1:    begin unit = job_reg.awb[1]; golden = job_reg.awb[4]; end
            default: begin unit = job_reg.awb[2]; golden = job_reg.awb[5]; end
        endcase
        diff = (unit > golden) ? unit - golden : golden - unit;
    end

    // One restoring divide step per cycle
    assign rsh = {rem_reg, num_reg[NB-1]};
    assign ge = rsh >= {1'b0, dvs_reg};

    // Saturate metric and decide whether the AWB result is out of limit
    always_comb
    begin
        if (zero_reg || acc_reg > {1'b0, ocv_pkg::METRIC_ONES})
            metric = ocv_pkg::METRIC_ONES;
        else
            metric = acc_reg[ocv_pkg::METRIC_W-1:0];
        awb_out = zero_reg || (metric > {22'd0, awb_limit});
    end

    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        term_next = term_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        acc_next = acc_reg;
        zero_next = zero_reg;
        ov_next = ov_reg && !pop;
        st_next = st_reg;
        met_next = met_reg;
        job_pop = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop = 1'b1;
                    job_next = job;
                    term_next = '0;
                    acc_next = '0;
                    zero_next = any_zero;
                    state_next = any_zero ? S_DONE : S_PREP;
                end
            end
            S_PREP:
            begin
                num_next = {32'(diff) * 32'(diff), ocv_pkg::FRAC_SHIFT'(0)};
                dvs_next = 32'(golden) * 32'(golden);
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? 32'(rsh - {1'b0, dvs_reg}) : rsh[31:0];
                quo_next = {quo_reg[NB-2:0], ge};
                num_next = {num_reg[NB-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg + AW'(quo_reg);
                if (term_reg == 2'd2)
                    state_next = S_DONE;
                else
                begin
                    term_next = term_reg + 1'b1;
                    state_next = S_PREP;
                end
            end
            S_DONE:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    met_next = metric;
                    if (job_reg.flag_fail)
                        st_next = ocv_pkg::ST_GROUP_BAD;
                    else if (job_reg.info_fail)
                        st_next = ocv_pkg::ST_INFO_BAD;
                    else if (job_reg.sum_fail)
                        st_next = ocv_pkg::ST_SUM_BAD;
                    else if (awb_out)
                        st_next = ocv_pkg::ST_AWB_BAD;
                    else
                        st_next = ocv_pkg::ST_NORMAL;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        term_reg <= term_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        acc_reg <= acc_next;
        zero_reg <= zero_next;
        st_reg <= st_next;
        met_reg <= met_next;
    end

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign awb_metric = met_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dvs_reg != '0)
        else $error("divide by zero golden");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == CNT_LAST |=> state_reg == S_ACC)
        else $error("divide did not finish after all bits");

endmodule

[rtl/camera_otp_calibration_validator_core.sv]
// Calibration image checker. Push one image byte per cycle, in address order from
// offset zero; a full image is 6781 bytes and yields one result transaction on the
// result side carrying status and the AWB deviation metric. The front end takes a
// byte every cycle while full is low and starts on the next image at once; the
// finished images wait in a small queue (QUEUE_DEPTH entries) for the back end.
// Per image the back end runs three terms, each a prepare step, a 52-bit serial
// divide and an accumulate, then a done state registers the result; a zero golden
// word skips the terms. full rises while the queue holds QUEUE_DEPTH finished
// images, then holds off every byte, even mid image. Write registers while idle.
module camera_otp_calibration_validator_core #(
    parameter int QUEUE_DEPTH = ocv_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  eeprom_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [53:0] awb_metric,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ocv_pkg::cfg_t cfg_reg;
    ocv_pkg::job_t front_job, back_job;
    logic          job_push, job_pop, q_full, q_empty, accept, out_valid;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= ocv_pkg::CFG_RESET;
        else if (cfg_write)
        begin
            case (cfg_index)
                ocv_pkg::REG_MODULE_ID:   cfg_reg.module_id <= cfg_data[7:0];
                ocv_pkg::REG_LENS_ID:     cfg_reg.lens_id <= cfg_data[7:0];
                ocv_pkg::REG_VCM_ID:      cfg_reg.vcm_id <= cfg_data[7:0];
                ocv_pkg::REG_DRIVER_ID:   cfg_reg.driver_id <= cfg_data[7:0];
                ocv_pkg::REG_PLATFORM_ID: cfg_reg.platform_id <= cfg_data[7:0];
                ocv_pkg::REG_CAL_VERSION: cfg_reg.cal_version <= cfg_data;
                ocv_pkg::REG_AWB_LIMIT:   cfg_reg.awb_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    assign full = q_full;
    assign accept = push && !q_full;
    assign empty = !out_valid;

    ocv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .eeprom_byte (eeprom_byte),
        .cfg         (cfg_reg),
        .job_push    (job_push),
        .job         (front_job)
    );

    ocv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .rd_en   (job_pop),
        .rd_data (back_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    ocv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (q_empty),
        .job        (back_job),
        .job_pop    (job_pop),
        .awb_limit  (cfg_reg.awb_limit),
        .pop        (pop),
        .out_valid  (out_valid),
        .status     (status),
        .awb_metric (awb_metric)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ocv_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 45000;
    localparam int STALL_LIMIT = 200000;
    localparam int DIRECTED_IMAGES = 9;
    localparam int RANDOM_IMAGES = 36;
    localparam int IMAGES_PER_PHASE = 6;

    typedef enum int {
        IMG_GOOD, IMG_FLAG_BAD, IMG_ID_BAD, IMG_VER_BAD, IMG_SUM_BAD,
        IMG_GOLD_ZERO, IMG_AWB_FAR, IMG_NOISE, IMG_AWB_MAX
    } image_kind_t;

    typedef struct {
        logic [2:0]  status;
        logic [53:0] metric;
    } verdict_t;

    // Tracks the image being streamed and predicts its verdict
    class scoreboard_t;
        cfg_t              regs;
        logic [OFF_W-1:0]  offset;
        logic [18:0]       section_sum;
        logic              flag_fail, id_fail, sum_fail;
        logic [31:0]       version;
        logic [15:0]       awb [AWB_WORDS];
        verdict_t          verdict_q[$];
        int                errors, checked;
        int                status_hist[5];

        function new();
            regs = CFG_RESET;
            errors = 0;
            checked = 0;
            foreach (status_hist[i]) status_hist[i] = 0;
            foreach (awb[i]) awb[i] = '0;
            clear_image();
        endfunction

        function void clear_image();
            offset = '0;
            section_sum = '0;
            flag_fail = 1'b0;
            id_fail = 1'b0;
            sum_fail = 1'b0;
            version = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_MODULE_ID:   regs.module_id = val[7:0];
                REG_LENS_ID:     regs.lens_id = val[7:0];
                REG_VCM_ID:      regs.vcm_id = val[7:0];
                REG_DRIVER_ID:   regs.driver_id = val[7:0];
                REG_PLATFORM_ID: regs.platform_id = val[7:0];
                REG_CAL_VERSION: regs.cal_version = val;
                REG_AWB_LIMIT:   regs.awb_limit = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] deviation(logic [15:0] unit, logic [15:0] golden);
            logic [63:0] d, g;
            d = (unit > golden) ? 64'(unit - golden) : 64'(golden - unit);
            g = 64'(golden);
            return ((d * d) << FRAC_SHIFT) / (g * g);
        endfunction

        // Advance the image state by one accepted byte transaction
        function void note_byte(logic [7:0] b);
            logic [63:0] metric;
            logic        awb_out;
            verdict_t    v;
            int          rel;
            for (int k = 0; k < SECTIONS; k++) begin
                if (offset == SEC_FIRST[k]) begin
                    if (b != SEC_FLAG) flag_fail = 1'b1;
                    section_sum = '0;
                end else if (offset == SEC_CHECK[k]) begin
                    if (32'(b) != (32'(section_sum) % 255) + 1) sum_fail = 1'b1;
                end else if (offset > SEC_FIRST[k] && offset < SEC_CHECK[k]) begin
                    section_sum = section_sum + 19'(b);
                end
            end
            case (offset)
                OFF_MODULE_ID:   if (b != regs.module_id) id_fail = 1'b1;
                OFF_PLATFORM_ID: if (b != regs.platform_id) id_fail = 1'b1;
                OFF_LENS_ID:     if (b != regs.lens_id) id_fail = 1'b1;
                OFF_VCM_ID:      if (b != regs.vcm_id) id_fail = 1'b1;
                OFF_DRIVER_ID:   if (b != regs.driver_id) id_fail = 1'b1;
                default: ;
            endcase
            if (offset >= OFF_VER_FIRST && offset <= OFF_VER_LAST)
                version = {version[23:0], b};
            if (offset >= OFF_AWB_FIRST && offset <= OFF_AWB_LAST) begin
                rel = int'(offset - OFF_AWB_FIRST);
                if (rel % 2 == 0) awb[rel / 2][15:8] = b;
                else awb[rel / 2][7:0] = b;
            end
            if (offset < LAST_OFFSET) begin
                offset = offset + 1'b1;
                return;
            end
            // Last byte: form the verdict
            if (awb[3] == 0 || awb[4] == 0 || awb[5] == 0) begin
                metric = 64'(METRIC_ONES);
                awb_out = 1'b1;
            end else begin
                metric = deviation(awb[0], awb[3]) + deviation(awb[1], awb[4])
                       + deviation(awb[2], awb[5]);
                if (metric > 64'(METRIC_ONES)) metric = 64'(METRIC_ONES);
                awb_out = metric > 64'(regs.awb_limit);
            end
            if (flag_fail) v.status = ST_GROUP_BAD;
            else if (id_fail || version != regs.cal_version) v.status = ST_INFO_BAD;
            else if (sum_fail) v.status = ST_SUM_BAD;
            else if (awb_out) v.status = ST_AWB_BAD;
            else v.status = ST_NORMAL;
            v.metric = metric[53:0];
            verdict_q.push_back(v);
            clear_image();
        endfunction

        // Compare one result transaction with the oldest verdict
        function void check_result(logic [2:0] st, logic [53:0] metric);
            verdict_t v;
            if (verdict_q.size() == 0) begin
                $error("unexpected result: status %0d awb_metric %0d", st, metric);
                errors++;
                return;
            end
            v = verdict_q.pop_front();
            checked++;
            if (v.status <= ST_AWB_BAD) status_hist[v.status]++;
            if (st !== v.status) begin
                $error("status: expected %0d, actual %0d", v.status, st);
                errors++;
            end
            if (metric !== v.metric) begin
                $error("awb_metric: expected %0d, actual %0d", v.metric, metric);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  eeprom_byte;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [53:0] awb_metric;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    scoreboard_t  sb;
    logic [7:0]   image [IMAGE_BYTES];
    logic         calm;
    int           stall_count;
    int           images_sent;

    camera_otp_calibration_validator_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .eeprom_byte(eeprom_byte), .empty(empty), .pop(pop),
        .status(status), .awb_metric(awb_metric),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Write all registers plus the unused index, back to back
    task automatic write_regs(cfg_t c);
        logic [31:0] vals [8];
        vals[REG_MODULE_ID]   = 32'(c.module_id);
        vals[REG_LENS_ID]     = 32'(c.lens_id);
        vals[REG_VCM_ID]      = 32'(c.vcm_id);
        vals[REG_DRIVER_ID]   = 32'(c.driver_id);
        vals[REG_PLATFORM_ID] = 32'(c.platform_id);
        vals[REG_CAL_VERSION] = c.cal_version;
        vals[REG_AWB_LIMIT]   = c.awb_limit;
        vals[REG_UNUSED]      = $urandom;
        for (int i = 0; i < 8; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_reg(3'(i), vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    // Hold the sender until every verdict has arrived, then let the back end settle
    task automatic drain();
        push <= 1'b0;
        while (sb.verdict_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic fix_checksums();
        int s;
        for (int k = 0; k < SECTIONS; k++) begin
            s = 0;
            for (int a = int'(SEC_FIRST[k]) + 1; a < int'(SEC_CHECK[k]); a++)
                s += image[a];
            image[SEC_CHECK[k]] = 8'((s % 255) + 1);
        end
    endtask

    // Fill the image buffer with a well-formed image and break it as asked, or with noise
    task automatic build_image(image_kind_t kind);
        logic [15:0] gold, unit, delta;
        int          base, k;
        foreach (image[i]) image[i] = 8'($urandom);
        if (kind == IMG_NOISE) return;
        for (k = 0; k < SECTIONS; k++) image[SEC_FIRST[k]] = SEC_FLAG;
        image[OFF_MODULE_ID]   = sb.regs.module_id;
        image[OFF_PLATFORM_ID] = sb.regs.platform_id;
        image[OFF_LENS_ID]     = sb.regs.lens_id;
        image[OFF_VCM_ID]      = sb.regs.vcm_id;
        image[OFF_DRIVER_ID]   = sb.regs.driver_id;
        for (k = 0; k < 4; k++)
            image[int'(OFF_VER_FIRST) + k] = sb.regs.cal_version[31 - 8*k -: 8];
        base = int'(OFF_AWB_FIRST);
        for (k = 0; k < 3; k++) begin
            gold = 16'($urandom_range(65535, 1));
            if (kind == IMG_AWB_MAX) begin
                gold = (k == 0) ? 16'd1 : 16'hFFFF;
                unit = (k == 0) ? 16'hFFFF : 16'h0000;
            end else if (kind == IMG_AWB_FAR) begin
                unit = 16'($urandom);
            end else begin
                delta = 16'($urandom_range(int'(gold) / 32, 0));
                unit = ($urandom_range(1, 0) == 1 && 32'(gold) + delta <= 65535)
                     ? gold + delta : gold - delta;
            end
            if (kind == IMG_GOLD_ZERO && k == 2) gold = 16'd0;
            image[base + 2*k]     = unit[15:8];
            image[base + 2*k + 1] = unit[7:0];
            image[base + 6 + 2*k]     = gold[15:8];
            image[base + 6 + 2*k + 1] = gold[7:0];
        end
        fix_checksums();
        k = $urandom_range(SECTIONS - 1, 0);
        case (kind)
            IMG_FLAG_BAD: image[SEC_FIRST[k]] ^= 8'($urandom_range(255, 2));
            IMG_SUM_BAD:  image[SEC_CHECK[k]] ^= 8'($urandom_range(255, 1));
            IMG_ID_BAD: begin
                case ($urandom_range(4, 0))
                    0: image[OFF_MODULE_ID] ^= 8'($urandom_range(255, 1));
                    1: image[OFF_PLATFORM_ID] ^= 8'($urandom_range(255, 1));
                    2: image[OFF_LENS_ID] ^= 8'($urandom_range(255, 1));
                    3: image[OFF_VCM_ID] ^= 8'($urandom_range(255, 1));
                    default: image[OFF_DRIVER_ID] ^= 8'($urandom_range(255, 1));
                endcase
            end
            IMG_VER_BAD:
                image[int'(OFF_VER_FIRST) + $urandom_range(3, 0)] ^= 8'($urandom_range(255, 1));
            default: ;
        endcase
    endtask

    // Stream the image buffer, one byte transaction at a time
    task automatic send_image();
        for (int a = 0; a < IMAGE_BYTES; a++) begin
            while (!calm && $urandom_range(99, 0) < 14) begin
                push <= 1'b0;
                eeprom_byte <= 8'($urandom);
                @(posedge clk);
            end
            push <= 1'b1;
            eeprom_byte <= image[a];
            @(posedge clk);
            while (full) @(posedge clk);
            sb.note_byte(image[a]);
        end
        images_sent++;
    endtask

    task automatic pick_regs(int phase, output cfg_t c);
        c.module_id   = 8'($urandom);
        c.lens_id     = 8'($urandom);
        c.vcm_id      = 8'($urandom);
        c.driver_id   = 8'($urandom);
        c.platform_id = 8'($urandom);
        c.cal_version = $urandom;
        c.awb_limit   = $urandom_range(200000, 0);
        if (phase % 4 == 1) c = '0;
        if (phase % 4 == 2) c = '1;
    endtask

    // Result side: random pops, with one long hold-off
    initial
    begin
        logic held;
        held = 1'b0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sb.checked == 3) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                pop <= calm || ($urandom_range(99, 0) >= 14);
                @(posedge clk);
                if (pop && !empty) sb.check_result(status, awb_metric);
            end
        end
    end

    // Watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("camera_otp_calibration_validator_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        image_kind_t kind;
        cfg_t        c;
        int          r;
        sb = new();
        stall_count = 0;
        images_sent = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        eeprom_byte = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, then one image of each kind
        for (int i = 0; i < DIRECTED_IMAGES; i++) begin
            build_image(image_kind_t'(i));
            send_image();
        end

        // Random phases with register changes between them
        for (int i = 0; i < RANDOM_IMAGES; i++) begin
            if (i % IMAGES_PER_PHASE == 0) begin
                drain();
                pick_regs(i / IMAGES_PER_PHASE, c);
                write_regs(c);
            end
            calm = (i == 8);
            r = $urandom_range(99, 0);
            if (r < 55) kind = IMG_GOOD;
            else if (r < 62) kind = IMG_FLAG_BAD;
            else if (r < 69) kind = IMG_ID_BAD;
            else if (r < 75) kind = IMG_VER_BAD;
            else if (r < 82) kind = IMG_SUM_BAD;
            else if (r < 87) kind = IMG_GOLD_ZERO;
            else if (r < 94) kind = IMG_AWB_FAR;
            else kind = IMG_NOISE;
            build_image(kind);
            send_image();
        end
        calm = 1'b0;
        push <= 1'b0;
        while (sb.verdict_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d images over several register settings, %0d verdicts checked",
                 images_sent, sb.checked);
        $display("verdicts normal %0d group %0d info %0d checksum %0d awb %0d",
                 sb.status_hist[0], sb.status_hist[1], sb.status_hist[2],
                 sb.status_hist[3], sb.status_hist[4]);
        if (sb.errors == 0)
            $display("camera_otp_calibration_validator_core regression: pass");
        else
            $display("camera_otp_calibration_validator_core regression: fail");
        $finish;
    end

endmodule
